>>> hdl/wsclock_page_replacer_macros.svh
// Assertion macros for the WS-Clock page replacer.
// Included by the top level only; no dependencies.
`ifndef WSCLOCK_PAGE_REPLACER_MACROS_SVH
`define WSCLOCK_PAGE_REPLACER_MACROS_SVH

// Implication checked every clock, masked during reset.
`define WPR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Same, with the consequent checked in the following cycle.
`define WPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/wpr_pkg.sv
// Shared types and constants for the WS-Clock page replacer.
// No dependencies.
`timescale 1ns / 1ps
package wpr_pkg;

  localparam int FRAMES_DEF = 64;
  localparam int PAGE_W     = 7;
  localparam int COUNT_W    = 7;   // width of the resident_count field
  localparam int REG_W      = 8;

  localparam logic [REG_W-1:0] TAU_RST    = 8'd50;
  localparam logic [REG_W-1:0] PERIOD_RST = 8'd50;

  localparam logic REG_TAU    = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  typedef struct packed {
    logic start;     // latch page, bump tick, clear result
    logic clr_idx;   // restart scan index, clear min tracker
    logic inc_idx;
    logic rd_next;   // read at idx+1
    logic rd_victim; // read at victim index
    logic hit_wr;
    logic append;
    logic vchk;      // evaluate one frame of the victim scan
    logic ev_cap;    // capture evicted page, idx <= victim
    logic sh_wr;     // move frame idx+1 down to idx
    logic set_last;  // count <= FRAMES-1
    logic wrap;      // period check
    logic load_out;
  } wpr_cmd_t;

  typedef struct packed {
    logic match;
    logic srch_end;
    logic full;
    logic scan_end;
    logic take;
    logic sh_end;
    logic out_free;
  } wpr_sts_t;

endpackage

>>> hdl/wpr_ctrl.sv
// Sequencer for the WS-Clock page replacer.
// Depends on wpr_pkg.
`timescale 1ns / 1ps
module wpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wpr_pkg::wpr_sts_t sts,
  output wpr_pkg::wpr_cmd_t cmd
);
  import wpr_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_SRCH_RD   = 13'b0000000000010,
    S_SRCH_CMP  = 13'b0000000000100,
    S_HIT_WR    = 13'b0000000001000,
    S_APPEND    = 13'b0000000010000,
    S_VSCAN_RD  = 13'b0000000100000,
    S_VSCAN_CHK = 13'b0000001000000,
    S_EV_RD     = 13'b0000010000000,
    S_EV_CAP    = 13'b0000100000000,
    S_SH_RD     = 13'b0001000000000,
    S_SH_WR     = 13'b0010000000000,
    S_WRAP      = 13'b0100000000000,
    S_FIN       = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts.srch_end) begin
          if (sts.full) begin
            cmd.clr_idx = 1'b1;
            state_next  = S_VSCAN_RD;
          end else begin
            state_next = S_APPEND;
          end
        end else begin
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.match) begin
          state_next = S_HIT_WR;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SRCH_RD;
        end
      end
      S_HIT_WR: begin
        cmd.hit_wr = 1'b1;
        state_next = S_WRAP;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_WRAP;
      end
      S_VSCAN_RD: begin
        if (sts.scan_end) begin
          state_next = S_EV_RD;
        end else begin
          state_next = S_VSCAN_CHK;
        end
      end
      S_VSCAN_CHK: begin
        cmd.vchk = 1'b1;
        if (sts.take) begin
          state_next = S_EV_RD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_VSCAN_RD;
        end
      end
      S_EV_RD: begin
        cmd.rd_victim = 1'b1;
        state_next    = S_EV_CAP;
      end
      S_EV_CAP: begin
        cmd.ev_cap = 1'b1;
        state_next = S_SH_RD;
      end
      S_SH_RD: begin
        if (sts.sh_end) begin
          cmd.set_last = 1'b1;
          state_next   = S_APPEND;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr   = 1'b1;
        cmd.inc_idx = 1'b1;
        state_next  = S_SH_RD;
      end
      S_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/wpr_dp.sv
// Datapath for the WS-Clock page replacer: frame memories, reference bits,
// tick, scan tracker, config registers and output register. Depends on wpr_pkg.
`timescale 1ns / 1ps
module wpr_dp #(
  parameter int FRAMES = wpr_pkg::FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wpr_pkg::wpr_cmd_t          cmd,
  output wpr_pkg::wpr_sts_t          sts,
  input  logic [wpr_pkg::PAGE_W-1:0] page_in,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [wpr_pkg::REG_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                out_data
);
  import wpr_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [PAGE_W-1:0] page_mem  [FRAMES];
  logic [REG_W-1:0]  stamp_mem [FRAMES];
  logic [FRAMES-1:0] ref_bits;

  logic [REG_W-1:0]  tau, period, tick;
  logic [PAGE_W-1:0] page;
  logic [CW-1:0]     count, idx;
  logic [IW-1:0]     victim;
  logic [REG_W-1:0]  best_stamp;
  logic              found;
  logic              hit, ev_valid;
  logic [PAGE_W-1:0] ev_page;

  logic [PAGE_W-1:0] rd_page;
  logic [REG_W-1:0]  rd_stamp;
  logic [IW-1:0]     rd_addr, wr_addr, idx_lo;
  logic [REG_W:0]    age;
  logic              cur_ref;

  assign idx_lo  = idx[IW-1:0];
  assign cur_ref = ref_bits[idx_lo];
  assign age     = {1'b0, tick} - {1'b0, rd_stamp};

  always_comb begin
    if (cmd.rd_victim) begin
      rd_addr = victim;
    end else if (cmd.rd_next) begin
      rd_addr = IW'(idx + 1'b1);
    end else begin
      rd_addr = idx_lo;
    end
    wr_addr = cmd.append ? count[IW-1:0] : idx_lo;
  end

  always_comb begin
    sts.match    = (rd_page == page);
    sts.srch_end = (idx == count);
    sts.full     = (count == CW'(FRAMES));
    sts.scan_end = (idx == CW'(FRAMES));
    sts.take     = !cur_ref && ($signed(age) > $signed({1'b0, tau}));
    sts.sh_end   = (idx == CW'(FRAMES - 1));
    sts.out_free = !out_valid || out_ready;
  end

  // frame memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    rd_page  <= page_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
    if (cmd.append || cmd.sh_wr) begin
      page_mem[wr_addr] <= cmd.append ? page : rd_page;
    end
    if (cmd.append || cmd.sh_wr || cmd.hit_wr) begin
      stamp_mem[wr_addr] <= cmd.sh_wr ? rd_stamp : tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tau       <= TAU_RST;
      period    <= PERIOD_RST;
      tick      <= '0;
      count     <= '0;
      ref_bits  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_TAU) begin
          tau <= cfg_data;
        end else begin
          period <= cfg_data;
        end
      end
      if (cmd.start) begin
        tick <= tick + 1'b1;
      end
      if (cmd.hit_wr || cmd.append) begin
        ref_bits[wr_addr] <= 1'b1;
      end
      if (cmd.vchk && cur_ref) begin
        ref_bits[idx_lo] <= 1'b0;
      end
      if (cmd.sh_wr) begin
        ref_bits[idx_lo] <= ref_bits[IW'(idx + 1'b1)];
      end
      if (cmd.append) begin
        count <= count + 1'b1;
      end else if (cmd.set_last) begin
        count <= CW'(FRAMES - 1);
      end
      if (cmd.wrap && (tick >= period)) begin
        ref_bits <= '0;
        tick     <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page     <= page_in;
      idx      <= '0;
      hit      <= 1'b0;
      ev_valid <= 1'b0;
      ev_page  <= '0;
    end
    if (cmd.clr_idx) begin
      idx    <= '0;
      found  <= 1'b0;
      victim <= '0;
    end
    if (cmd.inc_idx) begin
      idx <= idx + 1'b1;
    end
    if (cmd.hit_wr) begin
      hit <= 1'b1;
    end
    if (cmd.vchk && !cur_ref) begin
      if (sts.take) begin
        victim <= idx_lo;
      end else if (!found || (rd_stamp < best_stamp)) begin
        found      <= 1'b1;
        best_stamp <= rd_stamp;
        victim     <= idx_lo;
      end
    end
    if (cmd.ev_cap) begin
      ev_valid <= 1'b1;
      ev_page  <= rd_page;
      idx      <= CW'(victim);
    end
    if (cmd.load_out) begin
      out_data <= {COUNT_W'(count), ev_page, ev_valid, hit};
    end
  end

endmodule

>>> hdl/wsclock_page_replacer.sv
// Sequence: a hit ends the search at the matching frame; a miss with a free frame
// appends after searching all resident frames; a miss on a full table runs search,
// victim scan and shift-down, each pass through the single frame-memory read port.
// Throughput: one word in flight; the next word is taken once the result is registered.
// Reset: synchronous; clears count, tick, reference bits; tau and period return to 50.
// Frame page/stamp memories are not cleared: only entries below the count are read.
`timescale 1ns / 1ps
module wsclock_page_replacer #(
  parameter int FRAMES = wpr_pkg::FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [6:0] page_id
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] hit, [1] evicted_valid, [8:2] evicted_page, [15:9] resident_count
  output logic [15:0]               m_axis_tdata,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,      // 0 tau, 1 reset_period
  input  logic [wpr_pkg::REG_W-1:0] cfg_data
);
  import wpr_pkg::*;

`include "wsclock_page_replacer_macros.svh"

  wpr_cmd_t cmd;
  wpr_sts_t sts;

  // controller sequences search, victim scan and compaction
  wpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds the frame table and the result word
  wpr_dp #(.FRAMES(FRAMES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .page_in   (s_axis_tdata[PAGE_W-1:0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // busy right after taking a word
  `WPR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  // a hit never evicts
  `WPR_ASSERT(a_hit_no_evict, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "hit with eviction")
  // eviction only with a full table
  `WPR_ASSERT(a_evict_full, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[15:9] == COUNT_W'(FRAMES), "evict not full")

endmodule
